// File: rtl/bcld_pkg.sv
// Shared types and constants of the block cache LRU directory.
`default_nettype none
package bcld_pkg;

  localparam int NUM_WAYS_DEF   = 8;
  localparam int BLOCK_BITS_DEF = 48;
  localparam int STAMP_BITS_DEF = 32;

  // bit of (req_type - 2) that selects invalidate on a flush
  localparam int FLUSH_INV_BIT = 0;

  typedef enum logic [1:0] {
    REQ_READ      = 2'd0,
    REQ_WRITE     = 2'd1,
    REQ_FLUSH     = 2'd2,
    REQ_FLUSH_INV = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    KIND_ACCESS = 2'd0,
    KIND_WB     = 2'd1,
    KIND_DONE   = 2'd2,
    KIND_BYPASS = 2'd3
  } kind_e;

  typedef enum logic {
    REG_WRITE_THROUGH = 1'b0,
    REG_CACHE_OFF     = 1'b1
  } reg_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_e;

  // running result handed from cell to cell
  typedef struct packed {
    logic hit;
    logic unused;
    logic have;
    logic dirty;
  } carry_t;

  // entry update command broadcast to the cells
  typedef struct packed {
    logic en;
    logic valid_we;
    logic valid;
    logic dirty_we;
    logic dirty;
    logic tag_we;
    logic stamp_we;
  } upd_t;

endpackage
`default_nettype wire

// File: rtl/bcld_cell.sv
// One directory way: entry state plus one stage of the lookup/victim/flush scan chain.
`default_nettype none
module bcld_cell
  import bcld_pkg::*;
#(
  parameter int NUM_WAYS   = NUM_WAYS_DEF,
  parameter int BLOCK_BITS = BLOCK_BITS_DEF,
  parameter int STAMP_BITS = STAMP_BITS_DEF,
  parameter int IDX        = 0,
  localparam int WAY_BITS  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire  [BLOCK_BITS-1:0] key_i,
  input  wire                   flush_i,
  input  carry_t                carry_i,
  input  wire  [WAY_BITS-1:0]   carry_way_i,
  input  wire  [STAMP_BITS-1:0] carry_stamp_i,
  input  wire  [BLOCK_BITS-1:0] carry_tag_i,
  input  upd_t                  upd_i,
  input  wire  [WAY_BITS-1:0]   upd_way_i,
  input  wire  [STAMP_BITS-1:0] upd_stamp_i,
  output carry_t                carry_o,
  output logic [WAY_BITS-1:0]   carry_way_o,
  output logic [STAMP_BITS-1:0] carry_stamp_o,
  output logic [BLOCK_BITS-1:0] carry_tag_o
);

  logic                  valid_q, dirty_q;
  logic [BLOCK_BITS-1:0] tag_q;
  logic [STAMP_BITS-1:0] stamp_q;
  logic                  sel;

  carry_t                carry_d, carry_q;
  logic [WAY_BITS-1:0]   way_d, way_q;
  logic [STAMP_BITS-1:0] stamp_d, cstamp_q;
  logic [BLOCK_BITS-1:0] tag_d, ctag_q;

  assign sel = upd_i.en && (upd_way_i == WAY_BITS'(IDX));

  always_comb begin
    carry_d = carry_i;
    way_d   = carry_way_i;
    stamp_d = carry_stamp_i;
    tag_d   = carry_tag_i;
    if (flush_i) begin
      if (!carry_i.have && valid_q && dirty_q) begin
        carry_d.have  = 1'b1;
        carry_d.dirty = 1'b1;
        way_d         = WAY_BITS'(IDX);
        tag_d         = tag_q;
      end
    end else if (!carry_i.hit) begin
      if (valid_q && tag_q == key_i) begin
        carry_d.hit = 1'b1;
        way_d       = WAY_BITS'(IDX);
      end else if (!carry_i.unused) begin
        if (!valid_q) begin
          carry_d.unused = 1'b1;
          way_d          = WAY_BITS'(IDX);
        end else if (!carry_i.have || stamp_q < carry_stamp_i) begin
          carry_d.have  = 1'b1;
          carry_d.dirty = dirty_q;
          way_d         = WAY_BITS'(IDX);
          stamp_d       = stamp_q;
          tag_d         = tag_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      dirty_q <= 1'b0;
      carry_q <= '0;
    end else begin
      if (sel && upd_i.valid_we) valid_q <= upd_i.valid;
      if (sel && upd_i.dirty_we) dirty_q <= upd_i.dirty;
      carry_q <= carry_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sel && upd_i.tag_we) tag_q <= key_i;
    if (sel && upd_i.stamp_we) stamp_q <= upd_stamp_i;
    way_q    <= way_d;
    cstamp_q <= stamp_d;
    ctag_q   <= tag_d;
  end

  assign carry_o       = carry_q;
  assign carry_way_o   = way_q;
  assign carry_stamp_o = cstamp_q;
  assign carry_tag_o   = ctag_q;

endmodule
`default_nettype wire

// File: rtl/bcld_ctrl.sv
// Sequencer: request latch, scan timing, access clock, entry updates and result register.
`default_nettype none
module bcld_ctrl
  import bcld_pkg::*;
#(
  parameter int NUM_WAYS   = NUM_WAYS_DEF,
  parameter int BLOCK_BITS = BLOCK_BITS_DEF,
  parameter int STAMP_BITS = STAMP_BITS_DEF,
  localparam int WAY_BITS  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1,
  localparam int CNT_BITS  = $clog2(NUM_WAYS + 1)
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   start_i,
  input  wire  [1:0]            req_type_i,
  input  wire  [BLOCK_BITS-1:0] block_number_i,
  input  wire                   write_through_i,
  input  wire                   cache_off_i,
  output logic                  busy_o,
  output logic [BLOCK_BITS-1:0] key_o,
  output logic                  flush_o,
  input  carry_t                carry_i,
  input  wire  [WAY_BITS-1:0]   carry_way_i,
  input  wire  [BLOCK_BITS-1:0] carry_tag_i,
  output upd_t                  upd_o,
  output logic [WAY_BITS-1:0]   upd_way_o,
  output logic [STAMP_BITS-1:0] upd_stamp_o,
  output logic                  result_valid_o,
  output logic [1:0]            result_kind_o,
  output logic                  hit_o,
  output logic [WAY_BITS-1:0]   way_o,
  output logic                  fill_needed_o,
  output logic                  writeback_valid_o,
  output logic [BLOCK_BITS-1:0] writeback_block_o,
  output logic                  device_write_o,
  output logic                  last_o
);

  state_e                state_q, state_d;
  logic [CNT_BITS-1:0]   cnt_q, cnt_d;
  req_e                  req_q, req_d;
  logic [BLOCK_BITS-1:0] blk_q, blk_d;
  logic [STAMP_BITS-1:0] aclk_q, aclk_d;

  logic                  rv_d, rv_q;
  kind_e                 kind_d, kind_q;
  logic                  hit_d, hit_q, fill_d, fill_q, wbv_d, wbv_q, dw_d, dw_q, last_d, last_q;
  logic [WAY_BITS-1:0]   way_d, way_q;
  logic [BLOCK_BITS-1:0] wbb_d, wbb_q;

  logic accept, scan_done, is_flush, is_wr, more;

  assign accept    = start_i && (state_q == ST_IDLE);
  assign scan_done = (state_q == ST_SCAN) && (cnt_q == CNT_BITS'(NUM_WAYS));
  assign is_flush  = req_q[1];
  assign is_wr     = (req_q == REQ_WRITE);
  assign more      = is_flush && carry_i.have;

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    req_d   = req_q;
    blk_d   = blk_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          req_d = req_e'(req_type_i);
          blk_d = block_number_i;
          cnt_d = '0;
          if (req_type_i[1] || !cache_off_i) state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!scan_done) begin
          cnt_d = cnt_q + CNT_BITS'(1);
        end else if (more) begin
          cnt_d = '0;
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs: entry updates and next result
  always_comb begin
    upd_o       = '0;
    upd_way_o   = carry_way_i;
    upd_stamp_o = aclk_q + STAMP_BITS'(1);
    aclk_d      = aclk_q;
    rv_d        = 1'b0;
    kind_d      = KIND_ACCESS;
    hit_d       = 1'b0;
    way_d       = '0;
    fill_d      = 1'b0;
    wbv_d       = 1'b0;
    wbb_d       = '0;
    dw_d        = 1'b0;
    last_d      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && !req_type_i[1] && cache_off_i) begin
          rv_d   = 1'b1;
          kind_d = KIND_BYPASS;
          dw_d   = (req_type_i == REQ_WRITE);
          last_d = 1'b1;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          rv_d = 1'b1;
          if (is_flush) begin
            if (carry_i.have) begin
              kind_d         = KIND_WB;
              way_d          = carry_way_i;
              wbv_d          = 1'b1;
              wbb_d          = carry_tag_i;
              upd_o.en       = 1'b1;
              upd_o.dirty_we = 1'b1;
              upd_o.valid_we = req_q[FLUSH_INV_BIT];
            end else begin
              kind_d = KIND_DONE;
              last_d = 1'b1;
            end
          end else begin
            kind_d         = KIND_ACCESS;
            way_d          = carry_way_i;
            dw_d           = is_wr && write_through_i;
            last_d         = 1'b1;
            aclk_d         = aclk_q + STAMP_BITS'(1);
            upd_o.en       = 1'b1;
            upd_o.stamp_we = 1'b1;
            upd_o.dirty    = is_wr && !write_through_i;
            if (carry_i.hit) begin
              hit_d          = 1'b1;
              upd_o.dirty_we = is_wr;
            end else begin
              fill_d         = !is_wr;
              wbv_d          = !carry_i.unused && carry_i.dirty;
              wbb_d          = wbv_d ? carry_tag_i : '0;
              upd_o.dirty_we = 1'b1;
              upd_o.valid_we = 1'b1;
              upd_o.valid    = 1'b1;
              upd_o.tag_we   = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      req_q   <= REQ_READ;
      aclk_q  <= '0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      req_q   <= req_d;
      aclk_q  <= aclk_d;
      rv_q    <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q  <= blk_d;
    kind_q <= kind_d;
    hit_q  <= hit_d;
    way_q  <= way_d;
    fill_q <= fill_d;
    wbv_q  <= wbv_d;
    wbb_q  <= wbb_d;
    dw_q   <= dw_d;
    last_q <= last_d;
  end

  assign busy_o            = (state_q != ST_IDLE);
  assign key_o             = blk_q;
  assign flush_o           = is_flush;
  assign result_valid_o    = rv_q;
  assign result_kind_o     = kind_q;
  assign hit_o             = hit_q;
  assign way_o             = way_q;
  assign fill_needed_o     = fill_q;
  assign writeback_valid_o = wbv_q;
  assign writeback_block_o = wbb_q;
  assign device_write_o    = dw_q;
  assign last_o            = last_q;

endmodule
`default_nettype wire

// File: rtl/block_cache_lru_directory_core.sv
// Top level of the block cache LRU directory: config registers, way cell chain, sequencer.
`default_nettype none
// Tag directory of a NUM_WAYS-way fully associative LRU write-back block cache.
// A request is taken when start_i is high and busy_o is low; results come one per
// cycle-wide pulse of result_valid_o and must be taken as they appear. Each way is
// a cell in a chain; a scan moves through the chain one cell per clock, and a read
// or write answers once the scan has left the last cell. A flush rescans the chain
// after every write-back, until no dirty entry is found. With cache_off set, reads
// and writes answer in the next cycle and busy_o stays low.
// Registers over APB: write_through at 0x0, cache_off at 0x4 (bit 0).
module block_cache_lru_directory_core
  import bcld_pkg::*;
#(
  parameter int NUM_WAYS   = NUM_WAYS_DEF,
  parameter int BLOCK_BITS = BLOCK_BITS_DEF,
  parameter int STAMP_BITS = STAMP_BITS_DEF,
  localparam int WAY_BITS  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   psel,
  input  wire                   penable,
  input  wire                   pwrite,
  input  wire  [2:0]            paddr,
  input  wire  [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  wire                   start_i,
  output logic                  busy_o,
  input  wire  [1:0]            req_type_i,
  input  wire  [BLOCK_BITS-1:0] block_number_i,
  output logic                  result_valid_o,
  output logic [1:0]            result_kind_o,
  output logic                  hit_o,
  output logic [WAY_BITS-1:0]   way_o,
  output logic                  fill_needed_o,
  output logic                  writeback_valid_o,
  output logic [BLOCK_BITS-1:0] writeback_block_o,
  output logic                  device_write_o,
  output logic                  last_o
);

  logic wt_q, co_q, cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wt_q <= 1'b0;
      co_q <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_e'(paddr[2]))
        REG_WRITE_THROUGH: wt_q <= pwdata[0];
        REG_CACHE_OFF:     co_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_e'(paddr[2]))
      REG_WRITE_THROUGH: prdata[0] = wt_q;
      REG_CACHE_OFF:     prdata[0] = co_q;
      default: ;
    endcase
  end

  logic [BLOCK_BITS-1:0] key;
  logic                  flush;
  upd_t                  upd;
  logic [WAY_BITS-1:0]   upd_way;
  logic [STAMP_BITS-1:0] upd_stamp;

  carry_t                c_flags [NUM_WAYS+1];
  logic [WAY_BITS-1:0]   c_way   [NUM_WAYS+1];
  logic [STAMP_BITS-1:0] c_stamp [NUM_WAYS+1];
  logic [BLOCK_BITS-1:0] c_tag   [NUM_WAYS+1];

  assign c_flags[0] = '0;
  assign c_way[0]   = '0;
  assign c_stamp[0] = '0;
  assign c_tag[0]   = '0;

  for (genvar g = 0; g < NUM_WAYS; g++) begin : g_cell
    bcld_cell #(
      .NUM_WAYS  (NUM_WAYS),
      .BLOCK_BITS(BLOCK_BITS),
      .STAMP_BITS(STAMP_BITS),
      .IDX       (g)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .key_i        (key),
      .flush_i      (flush),
      .carry_i      (c_flags[g]),
      .carry_way_i  (c_way[g]),
      .carry_stamp_i(c_stamp[g]),
      .carry_tag_i  (c_tag[g]),
      .upd_i        (upd),
      .upd_way_i    (upd_way),
      .upd_stamp_i  (upd_stamp),
      .carry_o      (c_flags[g+1]),
      .carry_way_o  (c_way[g+1]),
      .carry_stamp_o(c_stamp[g+1]),
      .carry_tag_o  (c_tag[g+1])
    );
  end

  bcld_ctrl #(
    .NUM_WAYS  (NUM_WAYS),
    .BLOCK_BITS(BLOCK_BITS),
    .STAMP_BITS(STAMP_BITS)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .req_type_i       (req_type_i),
    .block_number_i   (block_number_i),
    .write_through_i  (wt_q),
    .cache_off_i      (co_q),
    .busy_o           (busy_o),
    .key_o            (key),
    .flush_o          (flush),
    .carry_i          (c_flags[NUM_WAYS]),
    .carry_way_i      (c_way[NUM_WAYS]),
    .carry_tag_i      (c_tag[NUM_WAYS]),
    .upd_o            (upd),
    .upd_way_o        (upd_way),
    .upd_stamp_o      (upd_stamp),
    .result_valid_o   (result_valid_o),
    .result_kind_o    (result_kind_o),
    .hit_o            (hit_o),
    .way_o            (way_o),
    .fill_needed_o    (fill_needed_o),
    .writeback_valid_o(writeback_valid_o),
    .writeback_block_o(writeback_block_o),
    .device_write_o   (device_write_o),
    .last_o           (last_o)
  );

  a_mid_is_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |-> result_kind_o == 2'(KIND_WB))
    else $error("non-final result is not a flush write-back");

  a_bypass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && !req_type_i[1] && co_q |=>
      result_valid_o && result_kind_o == 2'(KIND_BYPASS) && !busy_o)
    else $error("bypass request did not answer in the next cycle");

  a_wb_on_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && writeback_valid_o |-> !hit_o)
    else $error("write-back reported on a hit");

  a_busy_no_result_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_kind_o == 2'(KIND_WB) |-> busy_o)
    else $error("flush write-back delivered after sequencer went idle");

endmodule
`default_nettype wire

// File: tb/sv/block_cache_lru_directory_checker.sv
// Checker: tracks the LRU tag directory and scores every result of the block.
`timescale 1ns / 100ps
module block_cache_lru_directory_checker
  import bcld_pkg::*;
#(
  parameter int NUM_WAYS   = NUM_WAYS_DEF,
  parameter int BLOCK_BITS = BLOCK_BITS_DEF,
  parameter int STAMP_BITS = STAMP_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  input  logic                        pready,
  input  logic                        start_i,
  input  logic                        busy_i,
  input  logic [1:0]                  req_type_i,
  input  logic [BLOCK_BITS-1:0]       block_number_i,
  input  logic                        result_valid_i,
  input  logic [1:0]                  result_kind_i,
  input  logic                        hit_i,
  input  logic [$clog2(NUM_WAYS)-1:0] way_i,
  input  logic                        fill_needed_i,
  input  logic                        writeback_valid_i,
  input  logic [BLOCK_BITS-1:0]       writeback_block_i,
  input  logic                        device_write_i,
  input  logic                        last_i,
  output int                          fail_count_o,
  output int                          pending_o,
  output int                          requests_o,
  output int                          hits_o,
  output int                          writebacks_o,
  output int                          bypasses_o
);

  typedef struct packed {
    kind_e                       kind;
    logic                        hit;
    logic [$clog2(NUM_WAYS)-1:0] way;
    logic                        fill;
    logic                        wb_valid;
    logic [BLOCK_BITS-1:0]       wb_block;
    logic                        dev_write;
    logic                        last;
  } dir_result_t;

  logic [BLOCK_BITS-1:0] tag_r   [NUM_WAYS];
  logic                  valid_r [NUM_WAYS];
  logic                  dirty_r [NUM_WAYS];
  logic [STAMP_BITS-1:0] stamp_r [NUM_WAYS];
  logic [STAMP_BITS-1:0] access_clock_r;
  logic                  write_through_r;
  logic                  cache_off_r;

  dir_result_t due_results[$];

  function automatic dir_result_t make_result(kind_e k, logic h, int w, logic f, logic wbv,
                                              logic [BLOCK_BITS-1:0] wbb, logic dw, logic l);
    dir_result_t r;
    r.kind      = k;
    r.hit       = h;
    r.way       = w[$clog2(NUM_WAYS)-1:0];
    r.fill      = f;
    r.wb_valid  = wbv;
    r.wb_block  = wbb;
    r.dev_write = dw;
    r.last      = l;
    return r;
  endfunction

  task automatic queue_result(input dir_result_t r);
    due_results.push_back(r);
    if (r.kind == KIND_ACCESS && r.hit) hits_o++;
    if (r.wb_valid) writebacks_o++;
    if (r.kind == KIND_BYPASS) bypasses_o++;
  endtask

  task automatic run_request(input req_e rq, input logic [BLOCK_BITS-1:0] blk);
    int   hit_way;
    int   free_way;
    int   lru_way;
    int   slot;
    logic is_write;
    logic wbv;
    logic [BLOCK_BITS-1:0] wbb;
    is_write = (rq == REQ_WRITE);
    if (rq == REQ_FLUSH || rq == REQ_FLUSH_INV) begin
      for (int i = 0; i < NUM_WAYS; i++) begin
        if (valid_r[i] && dirty_r[i]) begin
          queue_result(make_result(KIND_WB, 1'b0, i, 1'b0, 1'b1, tag_r[i], 1'b0, 1'b0));
          dirty_r[i] = 1'b0;
          if (rq == REQ_FLUSH_INV) valid_r[i] = 1'b0;
        end
      end
      queue_result(make_result(KIND_DONE, 1'b0, 0, 1'b0, 1'b0, '0, 1'b0, 1'b1));
    end else if (cache_off_r) begin
      queue_result(make_result(KIND_BYPASS, 1'b0, 0, 1'b0, 1'b0, '0, is_write, 1'b1));
    end else begin
      hit_way  = -1;
      free_way = -1;
      lru_way  = -1;
      for (int i = 0; i < NUM_WAYS; i++) begin
        if (hit_way < 0) begin
          if (!valid_r[i]) begin
            if (free_way < 0) free_way = i;
          end else if (tag_r[i] == blk) begin
            hit_way = i;
          end else if (lru_way < 0 || stamp_r[i] < stamp_r[lru_way]) begin
            lru_way = i;
          end
        end
      end
      access_clock_r = access_clock_r + 1'b1;
      if (hit_way >= 0) begin
        stamp_r[hit_way] = access_clock_r;
        if (is_write) dirty_r[hit_way] = !write_through_r;
        queue_result(make_result(KIND_ACCESS, 1'b1, hit_way, 1'b0, 1'b0, '0,
                                 is_write & write_through_r, 1'b1));
      end else begin
        slot = (free_way >= 0) ? free_way : lru_way;
        if (slot < 0) slot = 0;
        wbv = valid_r[slot] && dirty_r[slot];
        wbb = wbv ? tag_r[slot] : '0;
        valid_r[slot] = 1'b1;
        dirty_r[slot] = is_write && !write_through_r;
        tag_r[slot]   = blk;
        stamp_r[slot] = access_clock_r;
        queue_result(make_result(KIND_ACCESS, 1'b0, slot, !is_write, wbv, wbb,
                                 is_write & write_through_r, 1'b1));
      end
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] exp, input logic [63:0] act);
    if (exp !== act) begin
      $error("%s: expected %0h, got %0h", name, exp, act);
      fail_count_o++;
    end
  endtask

  task automatic score_result();
    dir_result_t exp;
    if (due_results.size() == 0) begin
      $error("result with no transaction pending: kind %0d way %0d", result_kind_i, way_i);
      fail_count_o++;
    end else begin
      exp = due_results.pop_front();
      check_field("result_kind", exp.kind, result_kind_i);
      check_field("hit", exp.hit, hit_i);
      check_field("way", exp.way, way_i);
      check_field("fill_needed", exp.fill, fill_needed_i);
      check_field("writeback_valid", exp.wb_valid, writeback_valid_i);
      check_field("writeback_block", exp.wb_block, writeback_block_i);
      check_field("device_write", exp.dev_write, device_write_i);
      check_field("last", exp.last, last_i);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (tag_r[i]) begin
        tag_r[i]   = '0;
        valid_r[i] = 1'b0;
        dirty_r[i] = 1'b0;
        stamp_r[i] = '0;
      end
      access_clock_r  = '0;
      write_through_r = 1'b0;
      cache_off_r     = 1'b0;
      due_results.delete();
      fail_count_o = 0;
      pending_o    = 0;
      requests_o   = 0;
      hits_o       = 0;
      writebacks_o = 0;
      bypasses_o   = 0;
    end else begin
      if (result_valid_i) score_result();
      if (start_i && !busy_i) begin
        run_request(req_e'(req_type_i), block_number_i);
        requests_o++;
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[2])
          REG_WRITE_THROUGH: write_through_r = pwdata[0];
          REG_CACHE_OFF:     cache_off_r     = pwdata[0];
          default: ;
        endcase
      end
      pending_o = due_results.size();
    end
  end

endmodule

// File: tb/sv/block_cache_lru_directory_core_test.sv
// Testbench top: drives requests and register writes into the directory and reports the verdict.
`timescale 1ns / 100ps
module block_cache_lru_directory_core_test;
  import bcld_pkg::*;

  localparam int BB = BLOCK_BITS_DEF;
  localparam int WB = $clog2(NUM_WAYS_DEF);
  localparam logic [BB-1:0] BLK_MAX = '1;
  localparam int PHASES = 7;
  localparam int PHASE_ITEMS = 57;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          psel = 1'b0;
  logic          penable = 1'b0;
  logic          pwrite = 1'b0;
  logic [2:0]    paddr = '0;
  logic [31:0]   pwdata = '0;
  logic [31:0]   prdata;
  logic          pready;
  logic          start_i = 1'b0;
  logic          busy_o;
  logic [1:0]    req_type_i = REQ_READ;
  logic [BB-1:0] block_number_i = '0;
  logic          result_valid_o;
  logic [1:0]    result_kind_o;
  logic          hit_o;
  logic [WB-1:0] way_o;
  logic          fill_needed_o;
  logic          writeback_valid_o;
  logic [BB-1:0] writeback_block_o;
  logic          device_write_o;
  logic          last_o;

  int fail_count, pending, requests, hits, writebacks, bypasses;

  block_cache_lru_directory_core dut (.*);

  block_cache_lru_directory_checker u_scoreboard (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .start_i, .busy_i(busy_o), .req_type_i, .block_number_i,
    .result_valid_i(result_valid_o), .result_kind_i(result_kind_o), .hit_i(hit_o),
    .way_i(way_o), .fill_needed_i(fill_needed_o), .writeback_valid_i(writeback_valid_o),
    .writeback_block_i(writeback_block_o), .device_write_i(device_write_o), .last_i(last_o),
    .fail_count_o(fail_count), .pending_o(pending), .requests_o(requests), .hits_o(hits),
    .writebacks_o(writebacks), .bypasses_o(bypasses)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // entered and left just after a falling edge
  task automatic issue(input req_e rq, input logic [BB-1:0] blk, input int gap);
    if (gap > 0) begin
      start_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i        = 1'b1;
    req_type_i     = rq;
    block_number_i = blk;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input reg_e r, input logic v);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {r, 2'b00};
    pwdata  = {31'b0, v};
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic wait_idle();
    start_i = 1'b0;
    while (pending != 0 || busy_o) @(negedge clk_i);
  endtask

  task automatic set_config(input logic wt, input logic off);
    wait_idle();
    write_reg(REG_WRITE_THROUGH, wt);
    write_reg(REG_CACHE_OFF, off);
  endtask

  initial begin
    logic [BB-1:0] pool [12];
    logic [1:0]    phase_cfg [PHASES];
    logic [BB-1:0] blk;
    req_e          rq;
    int            roll;
    int            gap;

    phase_cfg = '{2'b00, 2'b10, 2'b01, 2'b00, 2'b11, 2'b10, 2'b00};
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    set_config(1'b0, 1'b0);
    issue(REQ_READ, '0, 0);
    issue(REQ_READ, BLK_MAX, 1);
    issue(REQ_READ, '0, 0);
    issue(REQ_WRITE, '0, 2);
    for (int k = 1; k <= 6; k++) issue(REQ_WRITE, BB'(k), 0);
    issue(REQ_READ, BB'(7), 3);              // clean LRU victim
    issue(REQ_READ, BB'(8), 0);              // dirty LRU victim, write-back
    issue(REQ_FLUSH, BLK_MAX, 0);
    issue(REQ_WRITE, 48'h5555_5555_5555, 1);
    issue(REQ_FLUSH_INV, '0, 0);
    issue(REQ_FLUSH_INV, BLK_MAX, 0);        // nothing dirty left
    set_config(1'b1, 1'b0);
    issue(REQ_WRITE, BB'(7), 0);             // write-through hit
    issue(REQ_WRITE, 48'hAAAA_AAAA_AAAA, 2); // write-through miss into freed way
    issue(REQ_FLUSH, '0, 0);
    set_config(1'b0, 1'b1);
    issue(REQ_READ, BB'(7), 0);
    issue(REQ_WRITE, BLK_MAX, 0);
    issue(REQ_FLUSH_INV, '0, 1);

    pool[0] = '0;
    pool[1] = BLK_MAX;
    for (int k = 2; k < 12; k++) pool[k] = BB'({$urandom, $urandom});

    for (int ph = 0; ph < PHASES; ph++) begin
      set_config(phase_cfg[ph][1], phase_cfg[ph][0]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 42)      rq = REQ_READ;
        else if (roll < 84) rq = REQ_WRITE;
        else if (roll < 92) rq = REQ_FLUSH;
        else                rq = REQ_FLUSH_INV;
        roll = $urandom_range(0, 99);
        if (roll < 70)      blk = pool[$urandom_range(0, 11)];
        else if (roll < 85) blk = BB'($urandom_range(0, 15));
        else                blk = BB'({$urandom, $urandom});
        gap = (n % 20 < 6) ? 0 : $urandom_range(0, 3);
        issue(rq, blk, gap);
      end
    end

    wait_idle();
    repeat (4 * (NUM_WAYS_DEF + 2)) @(negedge clk_i);
    $display("covered %0d requests over all write-through/cache-off settings: %0d hits,",
             requests, hits);
    $display("%0d dirty write-backs, %0d bypassed accesses", writebacks, bypasses);
    if (fail_count == 0) begin
      $display("block_cache_lru_directory_core_test: clean");
    end else begin
      $display("block_cache_lru_directory_core_test: errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("block_cache_lru_directory_core_test: errors");
    $finish;
  end

endmodule
